// ===== rtl/core/stf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stf_pkg
// Shared widths, constants and types of the scanline triangle filler.
// ----------------------------------------------------------------------------
package stf_pkg;

	localparam int CANVAS_WIDTH  = 320;
	localparam int CANVAS_HEIGHT = 240;

	localparam int X_W    = 9;
	localparam int Y_W    = 8;
	localparam int COL_W  = 24;
	localparam int FRAC_W = 16;
	localparam int POS_W  = 26;          // unsigned Q10.16 position
	localparam int STEP_W = FRAC_W + 1;  // step magnitude, up to 1.0
	localparam int DIV_W  = X_W + FRAC_W; // dividend width

	localparam logic [X_W-1:0] X_MAX      = X_W'(CANVAS_WIDTH - 1);
	localparam logic [Y_W-1:0] Y_MAX      = Y_W'(CANVAS_HEIGHT - 1);
	localparam logic [X_W-1:0] NO_MATCH_X = X_W'(1);
	localparam logic [POS_W-1:0] HALF_UNIT = POS_W'(32768);
	localparam logic [STEP_W-1:0] UNIT_STEP = STEP_W'(65536);

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_STEP = 1'b1;

	typedef struct packed {
		logic [X_W-1:0] x;
		logic [Y_W-1:0] y;
	} vert_t;

	// one queued word, vertices already clamped and sorted by row
	typedef struct packed {
		logic             cmd;
		vert_t [2:0]      v;
		logic [COL_W-1:0] colour;
	} entry_t;

	// edge walk request
	typedef struct packed {
		logic [X_W-1:0] xa;
		logic [Y_W-1:0] ya;
		logic [X_W-1:0] xb;
		logic [Y_W-1:0] yb;
		logic [Y_W-1:0] row;
	} walk_req_t;

endpackage

// ===== rtl/core/stf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stf_front
// Input side: clamps vertices to the canvas and sorts them by row (stable).
// ----------------------------------------------------------------------------
module stf_front (
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    cmd,
	input  logic [8:0]              vertex_a_x,
	input  logic [7:0]              vertex_a_y,
	input  logic [8:0]              vertex_b_x,
	input  logic [7:0]              vertex_b_y,
	input  logic [8:0]              vertex_c_x,
	input  logic [7:0]              vertex_c_y,
	input  logic [23:0]             fill_colour,
	input  logic                    q_full,
	output logic                    push,
	output stf_pkg::entry_t         entry
);
	import stf_pkg::*;

	vert_t v0, v1, v2, s0a, s1a, s1b, s2b, s0c, s1c;

	function automatic vert_t clamp(input logic [X_W-1:0] x, input logic [Y_W-1:0] y);
		vert_t r;
		r.x = (x > X_MAX) ? X_MAX : x;
		r.y = (y > Y_MAX) ? Y_MAX : y;
		return r;
	endfunction

	always_comb begin
		v0 = clamp(vertex_a_x, vertex_a_y);
		v1 = clamp(vertex_b_x, vertex_b_y);
		v2 = clamp(vertex_c_x, vertex_c_y);
		// bubble network, swap only on strictly greater: keeps tie order
		s0a = (v0.y > v1.y) ? v1 : v0;
		s1a = (v0.y > v1.y) ? v0 : v1;
		s1b = (s1a.y > v2.y) ? v2 : s1a;
		s2b = (s1a.y > v2.y) ? s1a : v2;
		s0c = (s0a.y > s1b.y) ? s1b : s0a;
		s1c = (s0a.y > s1b.y) ? s0a : s1b;
		entry.cmd    = cmd;
		entry.v[0]   = s0c;
		entry.v[1]   = s1c;
		entry.v[2]   = s2b;
		entry.colour = fill_colour;
	end

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

endmodule

// ===== rtl/core/stf_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stf_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module stf_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  stf_pkg::entry_t wdata,
	output logic            full,
	input  logic            pop,
	output logic            nonempty,
	output stf_pkg::entry_t rdata
);
	import stf_pkg::*;

	entry_t      mem_q [2];
	logic        wr_q, rd_q;
	logic [1:0]  cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign nonempty = (cnt_q != 2'd0);
	assign rdata    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// ===== rtl/core/stf_edge_walk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stf_edge_walk
// DDA walk of one edge: serial divide for the minor step, then one step a
// cycle until the rounded row matches or the edge's steps run out.
// ----------------------------------------------------------------------------
module stf_edge_walk (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  stf_pkg::walk_req_t        req,
	output logic                      done,
	output logic [stf_pkg::X_W-1:0]   x
);
	import stf_pkg::*;

	typedef enum logic [1:0] {W_IDLE, W_DIV, W_RUN} wstate_t;

	wstate_t            state_q;
	logic               xneg_q, yneg_q, xmaj_q;
	logic [X_W-1:0]     n_q, i_q, rem_q;
	logic [Y_W-1:0]     row_q;
	logic [POS_W-1:0]   px_q, py_q;
	logic [DIV_W-1:0]   dd_q;
	logic [STEP_W-1:0]  quo_q, sx_q, sy_q;
	logic [4:0]         cnt_q;
	logic               done_q;
	logic [X_W-1:0]     x_q;

	logic               xneg, yneg;
	logic [X_W-1:0]     adx, ady, n, m;
	logic [X_W:0]       trial;
	logic               ge;
	logic [STEP_W-1:0]  quo_nx;
	logic [POS_W-1:0]   rx, ry;

	always_comb begin
		xneg  = req.xb < req.xa;
		yneg  = req.yb < req.ya;
		adx   = xneg ? (req.xa - req.xb) : (req.xb - req.xa);
		ady   = X_W'(yneg ? (req.ya - req.yb) : (req.yb - req.ya));
		n     = (adx > ady) ? adx : ady;
		m     = (adx > ady) ? ady : adx;
		trial = {rem_q, dd_q[DIV_W-1]};
		ge    = trial >= {1'b0, n_q};
		quo_nx = {quo_q[STEP_W-2:0], ge};
		rx    = px_q + HALF_UNIT;
		ry    = py_q + HALF_UNIT;
	end

	assign done = done_q;
	assign x    = x_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= W_IDLE;
			done_q  <= 1'b0;
			x_q     <= '0;
			xneg_q  <= 1'b0;
			yneg_q  <= 1'b0;
			xmaj_q  <= 1'b0;
			n_q     <= '0;
			i_q     <= '0;
			rem_q   <= '0;
			row_q   <= '0;
			px_q    <= '0;
			py_q    <= '0;
			dd_q    <= '0;
			quo_q   <= '0;
			sx_q    <= '0;
			sy_q    <= '0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				W_IDLE: begin
					if (start) begin
						if (n == '0) begin
							done_q <= 1'b1;
							x_q    <= NO_MATCH_X;
						end else begin
							xneg_q  <= xneg;
							yneg_q  <= yneg;
							xmaj_q  <= adx > ady;
							n_q     <= n;
							row_q   <= req.row;
							dd_q    <= {m, FRAC_W'(0)} + DIV_W'(n >> 1);
							rem_q   <= '0;
							quo_q   <= '0;
							cnt_q   <= 5'(DIV_W - 1);
							i_q     <= '0;
							px_q    <= {1'b0, req.xa, FRAC_W'(0)};
							py_q    <= {2'b0, req.ya, FRAC_W'(0)};
							state_q <= W_DIV;
						end
					end
				end
				W_DIV: begin
					rem_q <= ge ? X_W'(trial - {1'b0, n_q}) : X_W'(trial);
					quo_q <= quo_nx;
					dd_q  <= {dd_q[DIV_W-2:0], 1'b0};
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd0) begin
						sx_q    <= xmaj_q ? UNIT_STEP : quo_nx;
						sy_q    <= xmaj_q ? quo_nx : UNIT_STEP;
						state_q <= W_RUN;
					end
				end
				W_RUN: begin
					if (ry[POS_W-1:FRAC_W] == {2'b0, row_q}) begin
						done_q  <= 1'b1;
						x_q     <= rx[FRAC_W+X_W-1:FRAC_W];
						state_q <= W_IDLE;
					end else if (i_q == n_q - X_W'(1)) begin
						done_q  <= 1'b1;
						x_q     <= NO_MATCH_X;
						state_q <= W_IDLE;
					end else begin
						i_q  <= i_q + X_W'(1);
						px_q <= xneg_q ? px_q - POS_W'(sx_q) : px_q + POS_W'(sx_q);
						py_q <= yneg_q ? py_q - POS_W'(sy_q) : py_q + POS_W'(sy_q);
					end
				end
				default: state_q <= W_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/core/stf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stf_back
// Executes queued words: loads a triangle, sets up rows, streams span pixels.
// ----------------------------------------------------------------------------
module stf_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      q_nonempty,
	input  stf_pkg::entry_t           q_data,
	output logic                      q_pop,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      pixel_valid,
	output logic [8:0]                pixel_x,
	output logic [7:0]                pixel_y,
	output logic [23:0]               pixel_color,
	output logic                      last_pixel,
	output logic                      walk_busy
);
	import stf_pkg::*;

	typedef enum logic [1:0] {B_IDLE, B_MID, B_EDGE_A, B_EDGE_B} bstate_t;

	bstate_t           state_q;
	vert_t [2:0]       v_q;
	logic [X_W-1:0]    mid_x_q, span_x_q, span_end_q;
	logic [Y_W-1:0]    row_q;
	logic [COL_W-1:0]  colour_q;
	logic              busy_q, start_q;
	logic              out_valid_q, pix_valid_q, last_q;
	logic [X_W-1:0]    pix_x_q;
	logic [Y_W-1:0]    pix_y_q;
	logic [COL_W-1:0]  pix_col_q;

	walk_req_t         req;
	logic              w_done;
	logic [X_W-1:0]    w_x;
	logic              out_free, top_half;
	logic [Y_W:0]      row_nx;

	stf_edge_walk u_walk (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.req    (req),
		.done   (w_done),
		.x      (w_x)
	);

	always_comb begin
		top_half = row_q < v_q[1].y;
		req.row  = row_q;
		case (state_q)
			B_MID: begin
				req.xa = v_q[0].x; req.ya = v_q[0].y;
				req.xb = v_q[2].x; req.yb = v_q[2].y;
				req.row = v_q[1].y;
			end
			B_EDGE_A: begin
				req.xa = top_half ? v_q[0].x : mid_x_q;
				req.ya = top_half ? v_q[0].y : v_q[1].y;
				req.xb = top_half ? mid_x_q : v_q[2].x;
				req.yb = top_half ? v_q[1].y : v_q[2].y;
			end
			default: begin
				req.xa = top_half ? v_q[0].x : v_q[1].x;
				req.ya = top_half ? v_q[0].y : v_q[1].y;
				req.xb = top_half ? v_q[1].x : v_q[2].x;
				req.yb = top_half ? v_q[1].y : v_q[2].y;
			end
		endcase
	end

	assign out_free  = !out_valid_q || !out_stall;
	assign q_pop     = (state_q == B_IDLE) && q_nonempty && out_free;
	assign row_nx    = {1'b0, row_q} + (Y_W+1)'(1);
	assign walk_busy = (state_q != B_IDLE);

	assign out_valid    = out_valid_q;
	assign pixel_valid  = pix_valid_q;
	assign pixel_x      = pix_x_q;
	assign pixel_y      = pix_y_q;
	assign pixel_color  = pix_col_q;
	assign last_pixel   = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			v_q         <= '0;
			mid_x_q     <= '0;
			span_x_q    <= '0;
			span_end_q  <= '0;
			row_q       <= '0;
			colour_q    <= '0;
			busy_q      <= 1'b0;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
			pix_valid_q <= 1'b0;
			pix_x_q     <= '0;
			pix_y_q     <= '0;
			pix_col_q   <= '0;
			last_q      <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (q_pop) begin
						out_valid_q <= 1'b1;
						pix_valid_q <= 1'b0;
						pix_x_q     <= '0;
						pix_y_q     <= '0;
						pix_col_q   <= '0;
						last_q      <= 1'b0;
						if (q_data.cmd == CMD_LOAD) begin
							v_q        <= q_data.v;
							colour_q   <= q_data.colour;
							row_q      <= q_data.v[0].y;
							busy_q     <= q_data.v[0].y < q_data.v[2].y;
							span_x_q   <= '0;
							span_end_q <= '0;
							start_q    <= 1'b1;
							state_q    <= B_MID;
						end else if (busy_q) begin
							pix_valid_q <= 1'b1;
							pix_x_q     <= span_x_q;
							pix_y_q     <= row_q;
							pix_col_q   <= colour_q;
							if (span_x_q != span_end_q) begin
								span_x_q <= (span_x_q < span_end_q) ?
									span_x_q + X_W'(1) : span_x_q - X_W'(1);
							end else begin
								row_q <= row_q + Y_W'(1);
								if (row_nx >= {1'b0, v_q[2].y}) begin
									busy_q <= 1'b0;
									last_q <= 1'b1;
								end else begin
									start_q <= 1'b1;
									state_q <= B_EDGE_A;
								end
							end
						end
					end
				end
				B_MID: begin
					if (w_done) begin
						mid_x_q <= w_x;
						if (busy_q) begin
							start_q <= 1'b1;
							state_q <= B_EDGE_A;
						end else begin
							state_q <= B_IDLE;
						end
					end
				end
				B_EDGE_A: begin
					if (w_done) begin
						span_x_q <= w_x;
						start_q  <= 1'b1;
						state_q  <= B_EDGE_B;
					end
				end
				B_EDGE_B: begin
					if (w_done) begin
						span_end_q <= w_x;
						state_q    <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/core/scanline_triangle_filler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scanline_triangle_filler
// Flat-color scanline triangle filler with DDA edge walks.
// ----------------------------------------------------------------------------
//  channel | handshake            | words
//  --------+----------------------+---------------------------------------
//  in      | in_valid / in_stall  | cmd, three vertices, fill_colour
//  out     | out_valid/ out_stall | pixel_valid, pixel_x/y, color, last
//
// One result word per input word, in order.
// Inside a span, step words stream at one pixel per cycle while the queue holds words and out_stall is low.
// A row change walks both edges of the row's span on the shared walker,
// each a serial divide followed by one DDA step per cycle until the row
// is found or the steps run out; a load runs the middle-x walk, plus both
// of the first row's edge walks unless the triangle is empty.
// Reset (arst_n low) empties the queue and drops any loaded triangle.
// in_stall rises when the two-entry queue is full; out_stall holds the
// output register and backs up into the queue.
// ----------------------------------------------------------------------------
module scanline_triangle_filler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd,
	input  logic [8:0]  vertex_a_x,
	input  logic [7:0]  vertex_a_y,
	input  logic [8:0]  vertex_b_x,
	input  logic [7:0]  vertex_b_y,
	input  logic [8:0]  vertex_c_x,
	input  logic [7:0]  vertex_c_y,
	input  logic [23:0] fill_colour,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        pixel_valid,
	output logic [8:0]  pixel_x,
	output logic [7:0]  pixel_y,
	output logic [23:0] pixel_color,
	output logic        last_pixel
);
	import stf_pkg::*;

	entry_t f_entry, q_data;
	logic   push, q_full, q_nonempty, q_pop, walk_busy;

	// front: clamp and sort at acceptance
	stf_front u_front (
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.vertex_a_x  (vertex_a_x),
		.vertex_a_y  (vertex_a_y),
		.vertex_b_x  (vertex_b_x),
		.vertex_b_y  (vertex_b_y),
		.vertex_c_x  (vertex_c_x),
		.vertex_c_y  (vertex_c_y),
		.fill_colour (fill_colour),
		.q_full      (q_full),
		.push        (push),
		.entry       (f_entry)
	);

	// decouples acceptance from the long edge walks
	stf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wdata    (f_entry),
		.full     (q_full),
		.pop      (q_pop),
		.nonempty (q_nonempty),
		.rdata    (q_data)
	);

	// back: row setup and span streaming
	stf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_nonempty   (q_nonempty),
		.q_data       (q_data),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pixel_valid  (pixel_valid),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.pixel_color  (pixel_color),
		.last_pixel   (last_pixel),
		.walk_busy    (walk_busy)
	);

	// words are only taken from the queue between walks
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !walk_busy)
		else $error("queue popped during edge walk");

	// a pop always fills the output register
	a_pop_out: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> out_valid)
		else $error("popped word produced no result");

	// emitted pixels stay on the canvas
	a_on_canvas: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && pixel_valid) |-> (pixel_x <= X_MAX && pixel_y <= Y_MAX))
		else $error("pixel off canvas");

	// last marks a real pixel
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last_pixel) |-> pixel_valid)
		else $error("last on idle word");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the scanline triangle filler.
// Loads triangles, streams their fill pixels through the step command, and
// checks every result word against a behavioral raster model kept here.
// ----------------------------------------------------------------------------
module tb;
	import stf_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        cmd;
	logic [8:0]  vertex_a_x;
	logic [7:0]  vertex_a_y;
	logic [8:0]  vertex_b_x;
	logic [7:0]  vertex_b_y;
	logic [8:0]  vertex_c_x;
	logic [7:0]  vertex_c_y;
	logic [23:0] fill_colour;
	logic        out_valid;
	logic        out_stall;
	logic        pixel_valid;
	logic [8:0]  pixel_x;
	logic [7:0]  pixel_y;
	logic [23:0] pixel_color;
	logic        last_pixel;

	scanline_triangle_filler u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd),
		.vertex_a_x(vertex_a_x), .vertex_a_y(vertex_a_y),
		.vertex_b_x(vertex_b_x), .vertex_b_y(vertex_b_y),
		.vertex_c_x(vertex_c_x), .vertex_c_y(vertex_c_y),
		.fill_colour(fill_colour),
		.out_valid(out_valid), .out_stall(out_stall),
		.pixel_valid(pixel_valid), .pixel_x(pixel_x), .pixel_y(pixel_y),
		.pixel_color(pixel_color), .last_pixel(last_pixel)
	);

	// expected pixel word
	typedef struct packed {
		logic        pv;
		logic [8:0]  x;
		logic [7:0]  y;
		logic [23:0] colour;
		logic        last;
	} pixel_word_t;

	pixel_word_t pixel_fifo[$];
	int errors;
	int words_sent;
	int pixels_seen;
	int triangles_loaded;

	// raster state of the model
	logic [8:0]  tri_x[3];
	logic [7:0]  tri_y[3];
	logic [8:0]  mid_x;
	logic [7:0]  row_now;
	logic [8:0]  run_x;
	logic [8:0]  run_end_x;
	logic [23:0] colour_now;
	logic        drawing;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// round a Q.16 value to integer, half away from zero
	function automatic longint round_fix(longint p);
		if (p >= 0)
			return (p + 32768) >>> 16;
		return -((-p + 32768) >>> 16);
	endfunction

	function automatic longint step_fix(longint d, longint n);
		longint ad, q;
		ad = d < 0 ? -d : d;
		q = (ad * 65536 + n / 2) / n;
		return d < 0 ? -q : q;
	endfunction

	// DDA walk: x at the first step landing on the row, else the no-match x
	function automatic logic [8:0] walk_x(longint xa, longint ya, longint xb,
			longint yb, longint row);
		longint dx, dy, n, sx, sy;
		dx = xb - xa;
		dy = yb - ya;
		n = (dx < 0 ? -dx : dx);
		if ((dy < 0 ? -dy : dy) > n)
			n = dy < 0 ? -dy : dy;
		if (n == 0)
			return NO_MATCH_X;
		sx = step_fix(dx, n);
		sy = step_fix(dy, n);
		for (longint i = 0; i < n; i++) begin
			if (round_fix(ya * 65536 + sy * i) == row)
				return 9'(round_fix(xa * 65536 + sx * i));
		end
		return NO_MATCH_X;
	endfunction

	function automatic void start_row();
		if (row_now < tri_y[1]) begin
			run_x     = walk_x(tri_x[0], tri_y[0], mid_x, tri_y[1], row_now);
			run_end_x = walk_x(tri_x[0], tri_y[0], tri_x[1], tri_y[1], row_now);
		end else begin
			run_x     = walk_x(mid_x, tri_y[1], tri_x[2], tri_y[2], row_now);
			run_end_x = walk_x(tri_x[1], tri_y[1], tri_x[2], tri_y[2], row_now);
		end
	endfunction

	// advance the model by one input word, queue its expected result
	function automatic void raster_predict(logic c, logic [8:0] ax, logic [7:0] ay,
			logic [8:0] bx, logic [7:0] by, logic [8:0] cx, logic [7:0] cy,
			logic [23:0] col);
		pixel_word_t w;
		logic [8:0] vx[3];
		logic [7:0] vy[3];
		logic [8:0] kx;
		logic [7:0] ky;
		int j;
		w = '0;
		if (c == CMD_LOAD) begin
			vx[0] = ax > X_MAX ? X_MAX : ax;
			vy[0] = ay > Y_MAX ? Y_MAX : ay;
			vx[1] = bx > X_MAX ? X_MAX : bx;
			vy[1] = by > Y_MAX ? Y_MAX : by;
			vx[2] = cx > X_MAX ? X_MAX : cx;
			vy[2] = cy > Y_MAX ? Y_MAX : cy;
			// stable insertion sort by row
			for (int i = 1; i < 3; i++) begin
				kx = vx[i];
				ky = vy[i];
				j = i - 1;
				while (j >= 0 && vy[j] > ky) begin
					vx[j+1] = vx[j];
					vy[j+1] = vy[j];
					j--;
				end
				vx[j+1] = kx;
				vy[j+1] = ky;
			end
			tri_x = vx;
			tri_y = vy;
			colour_now = col;
			mid_x = walk_x(vx[0], vy[0], vx[2], vy[2], vy[1]);
			row_now = vy[0];
			drawing = vy[0] < vy[2];
			run_x = '0;
			run_end_x = '0;
			if (drawing)
				start_row();
		end else if (drawing) begin
			w.pv = 1'b1;
			w.x = run_x;
			w.y = row_now;
			w.colour = colour_now;
			if (run_x != run_end_x) begin
				run_x = run_x < run_end_x ? run_x + 9'd1 : run_x - 9'd1;
			end else begin
				row_now++;
				if (row_now >= tri_y[2]) begin
					drawing = 1'b0;
					w.last = 1'b1;
				end else begin
					start_row();
				end
			end
		end
		pixel_fifo.insert(pixel_fifo.size(), w);
	endfunction

	// drive one word with a random lead-in gap, wait for acceptance
	task automatic send_word(logic c, logic [8:0] ax, logic [7:0] ay,
			logic [8:0] bx, logic [7:0] by, logic [8:0] cx, logic [7:0] cy,
			logic [23:0] col);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
		repeat (gap) @(negedge clk);
		in_valid    = 1'b1;
		cmd         = c;
		vertex_a_x  = ax;
		vertex_a_y  = ay;
		vertex_b_x  = bx;
		vertex_b_y  = by;
		vertex_c_x  = cx;
		vertex_c_y  = cy;
		fill_colour = col;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		raster_predict(c, ax, ay, bx, by, cx, cy, col);
		words_sent++;
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic send_load(logic [8:0] ax, logic [7:0] ay, logic [8:0] bx,
			logic [7:0] by, logic [8:0] cx, logic [7:0] cy, logic [23:0] col);
		triangles_loaded++;
		send_word(CMD_LOAD, ax, ay, bx, by, cx, cy, col);
	endtask

	// step with junk on the load-only fields, which must be ignored
	task automatic send_step();
		send_word(CMD_STEP, 9'($urandom), 8'($urandom), 9'($urandom), 8'($urandom),
			9'($urandom), 8'($urandom), 24'($urandom));
	endtask

	// step until the loaded triangle reports its last pixel, or a cap
	task automatic drain_triangle(int cap);
		for (int i = 0; i < cap && drawing; i++)
			send_step();
	endtask

	task automatic check_word();
		pixel_word_t e;
		if (pixel_fifo.size() == 0) begin
			$display("%0t: unexpected word pv=%0d x=%0d y=%0d", $time,
				pixel_valid, pixel_x, pixel_y);
			errors++;
			return;
		end
		e = pixel_fifo.pop_front();
		if (pixel_valid) pixels_seen++;
		if (pixel_valid !== e.pv) begin
			$display("%0t: pixel_valid exp %0d got %0d", $time, e.pv, pixel_valid);
			errors++;
		end
		if (pixel_x !== e.x) begin
			$display("%0t: pixel_x exp %0d got %0d", $time, e.x, pixel_x);
			errors++;
		end
		if (pixel_y !== e.y) begin
			$display("%0t: pixel_y exp %0d got %0d", $time, e.y, pixel_y);
			errors++;
		end
		if (pixel_color !== e.colour) begin
			$display("%0t: pixel_color exp %h got %h", $time, e.colour, pixel_color);
			errors++;
		end
		if (last_pixel !== e.last) begin
			$display("%0t: last_pixel exp %0d got %0d", $time, e.last, last_pixel);
			errors++;
		end
	endtask

	// result side: random stall per word, compare at the rising edge
	initial begin
		int hold;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
			out_stall = hold != 0;
			repeat (hold) @(negedge clk);
			out_stall = 1'b0;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			check_word();
		end
	end

	// corners, flat edges, clamping, degenerate and ordering cases
	task automatic test_directed();
		send_step();                                         // idle before any load
		send_load(9'd10, 8'd10, 9'd14, 8'd13, 9'd8, 8'd15, 24'hFFFFFF);
		drain_triangle(200);
		send_load(9'd5, 8'd7, 9'd9, 8'd7, 9'd20, 8'd7, 24'h000000);  // empty
		send_step();
		send_load(9'd511, 8'd255, 9'd511, 8'd250, 9'd318, 8'd237, 24'hA5A5A5); // clamp
		drain_triangle(200);
		send_load(9'd0, 8'd0, 9'd3, 8'd0, 9'd0, 8'd4, 24'h123456);   // flat top
		drain_triangle(200);
		send_load(9'd6, 8'd2, 9'd0, 8'd6, 9'd9, 8'd6, 24'h5A5A5A);   // flat bottom
		drain_triangle(200);
		send_load(9'd2, 8'd9, 9'd2, 8'd3, 9'd2, 8'd5, 24'h800001);   // vertical line
		drain_triangle(200);
		send_load(9'd30, 8'd1, 9'd1, 8'd3, 9'd12, 8'd4, 24'h00FF00); // descending span
		repeat (3) send_step();
		send_load(9'd1, 8'd1, 9'd2, 8'd2, 9'd3, 8'd3, 24'h0000FF);   // load mid-stream
		drain_triangle(200);
		send_step();                                         // idle after last
	endtask

	// mostly small random triangles fully drained, with aborts and idle steps
	task automatic test_random(int words);
		logic [8:0] bx;
		logic [7:0] by;
		int mode;
		while (words_sent < words) begin
			mode = $urandom_range(0, 9);
			bx = 9'($urandom_range(0, 300));
			by = 8'($urandom_range(0, 225));
			if (mode == 0) begin
				// full-range vertices, short peek only
				send_load(9'($urandom), 8'($urandom), 9'($urandom), 8'($urandom),
					9'($urandom), 8'($urandom), 24'($urandom));
				repeat ($urandom_range(1, 6)) send_step();
			end else if (mode == 1) begin
				send_step();
			end else begin
				send_load(bx + 9'($urandom_range(0, 12)), by + 8'($urandom_range(0, 8)),
					bx + 9'($urandom_range(0, 12)), by + 8'($urandom_range(0, 8)),
					bx + 9'($urandom_range(0, 12)), by + 8'($urandom_range(0, 8)),
					24'($urandom));
				if (mode == 2)
					repeat ($urandom_range(0, 5)) send_step();
				else
					drain_triangle(400);
			end
		end
	endtask

	initial begin
		errors = 0;
		words_sent = 0;
		pixels_seen = 0;
		triangles_loaded = 0;
		drawing = 1'b0;
		in_valid = 1'b0;
		cmd = CMD_STEP;
		vertex_a_x = '0;
		vertex_a_y = '0;
		vertex_b_x = '0;
		vertex_b_y = '0;
		vertex_c_x = '0;
		vertex_c_y = '0;
		fill_colour = '0;
		arst_n = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random(750);
		// wait for the tail, then allow slack before reporting
		while (pixel_fifo.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		$display("tb: %0d words, %0d triangles loaded, %0d pixels checked",
			words_sent, triangles_loaded, pixels_seen);
		if (errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

	// each row change walks both span edges; bound the run loosely
	initial begin
		#40ms;
		$display("tb: done, errors");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/stf_pkg.sv
rtl/core/stf_front.sv
rtl/core/stf_queue.sv
rtl/core/stf_edge_walk.sv
rtl/core/stf_back.sv
rtl/core/scanline_triangle_filler.sv
verif/tb.sv
